// ===== sv/svc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register codes and bit helpers for the shifter and video control block
package svc_pkg;

  localparam int SHIFT_TABLE_DEPTH = 2048;
  localparam int TABLE_AW          = $clog2(SHIFT_TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // register numbers within the 0x800x window
  localparam logic [3:0] REG_FLIP         = 4'd4;
  localparam logic [3:0] REG_SHIFT_COUNT  = 4'd8;
  localparam logic [3:0] REG_SHIFT_DATA   = 4'd9;
  localparam logic [3:0] REG_VIDEO        = 4'd11;
  localparam logic [3:0] REG_LIGHT_SCROLL = 4'd12;
  localparam logic [3:0] REG_LEFT_SCROLL  = 4'd13;
  localparam logic [3:0] REG_RIGHT_SCROLL = 4'd14;
  localparam logic [3:0] REG_VERT_SCROLL  = 4'd15;
  localparam logic [3:0] REG_SHIFT_LOW    = 4'd8;
  localparam logic [3:0] REG_SHIFT_HIGH   = 4'd9;

  // configuration port byte address of the cabinet switch
  localparam logic [1:0] CFG_ADDR_COCKTAIL = 2'd0;

  localparam logic [7:0] VSCROLL_MASK = 8'hfc;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  reg_addr;
    logic [7:0]  data;
    logic [10:0] table_addr;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       headlight_on;
    logic       swap_colors;
    logic [1:0] map_select;
    logic       fg_color_select;
    logic [7:0] vertical_scroll;
    logic [7:0] left_scroll;
    logic [7:0] right_scroll;
    logic [7:0] light_scroll;
    logic       flip_screen;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // wired permutation on the high result: bits 0-6 reversed, bit 7 dropped
  function automatic logic [7:0] perm7(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 7; i++) begin
      r[i] = v[6-i];
    end
    return r;
  endfunction

endpackage

// ===== sv/svc_ram.sv =====
`timescale 1ns / 1ps
// generic ram: one write port, two registered read ports
module svc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a_r,
  output logic [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/svc_core.sv =====
`timescale 1ns / 1ps
// register state, shift table lookup and result forming
module svc_core
  import svc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  logic    cocktail,
  output result_t res
);

  logic [2:0] shift_count_r, shift_count_nxt;
  logic [7:0] shift_low_r, shift_low_nxt;
  logic [7:0] shift_high_r, shift_high_nxt;
  logic       pend_r, pend_nxt;
  logic       headlight_r, headlight_nxt;
  logic       swap_r, swap_nxt;
  logic       fg_sel_r, fg_sel_nxt;
  logic [1:0] map_r, map_nxt;
  logic [7:0] vscroll_r, vscroll_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] right_r, right_nxt;
  logic [7:0] light_r, light_nxt;
  logic       flip_r, flip_nxt;

  logic [7:0] ram_a, ram_b;
  logic [7:0] shift_low_cur, shift_high_cur;
  logic       wr, rd, ld;

  assign wr = fire && (item.op == OP_WRITE);
  assign rd = fire && (item.op == OP_READ);
  assign ld = fire && (item.op == OP_LOAD);

  // lookup data lands in the cycle after the shift data write
  assign shift_low_cur  = pend_r ? ram_a : shift_low_r;
  assign shift_high_cur = pend_r ? perm7(ram_b) : shift_high_r;

  svc_ram #(
    .WIDTH (8),
    .DEPTH (SHIFT_TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .we        (ld),
    .waddr     (item.table_addr[TABLE_AW-1:0]),
    .wdata     (item.data),
    .re        (pend_nxt),
    .raddr_a   ({shift_count_r, item.data}),
    .raddr_b   ({~shift_count_r, rev8(item.data)}),
    .rdata_a_r (ram_a),
    .rdata_b_r (ram_b)
  );

  always_comb begin
    shift_count_nxt = shift_count_r;
    shift_low_nxt   = shift_low_cur;
    shift_high_nxt  = shift_high_cur;
    pend_nxt        = 1'b0;
    headlight_nxt   = headlight_r;
    swap_nxt        = swap_r;
    fg_sel_nxt      = fg_sel_r;
    map_nxt         = map_r;
    vscroll_nxt     = vscroll_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    light_nxt       = light_r;
    flip_nxt        = flip_r;
    if (wr) begin
      unique case (item.reg_addr)
        REG_FLIP: begin
          flip_nxt = cocktail & item.data[0];
        end
        REG_SHIFT_COUNT: begin
          shift_count_nxt = item.data[2:0];
        end
        REG_SHIFT_DATA: begin
          pend_nxt = 1'b1;
        end
        REG_VIDEO: begin
          headlight_nxt = item.data[0];
          swap_nxt      = item.data[2];
          map_nxt[1]    = item.data[3];
        end
        REG_LIGHT_SCROLL: begin
          light_nxt = item.data;
        end
        REG_LEFT_SCROLL: begin
          left_nxt = item.data;
        end
        REG_RIGHT_SCROLL: begin
          right_nxt = item.data;
        end
        REG_VERT_SCROLL: begin
          vscroll_nxt = 8'hff - (item.data & VSCROLL_MASK);
          map_nxt[0]  = item.data[0];
          fg_sel_nxt  = item.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.read_data = '0;
    if (rd) begin
      unique case (item.reg_addr)
        REG_SHIFT_LOW:  res.read_data = shift_low_cur;
        REG_SHIFT_HIGH: res.read_data = shift_high_cur;
        default:        res.read_data = '0;
      endcase
    end
    res.headlight_on    = headlight_nxt;
    res.swap_colors     = swap_nxt;
    res.map_select      = map_nxt;
    res.fg_color_select = fg_sel_nxt;
    res.vertical_scroll = vscroll_nxt;
    res.left_scroll     = left_nxt;
    res.right_scroll    = right_nxt;
    res.light_scroll    = light_nxt;
    res.flip_screen     = flip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_count_r <= '0;
      shift_low_r   <= '0;
      shift_high_r  <= '0;
      pend_r        <= 1'b0;
      headlight_r   <= 1'b0;
      swap_r        <= 1'b0;
      fg_sel_r      <= 1'b0;
      map_r         <= '0;
      vscroll_r     <= '0;
      left_r        <= '0;
      right_r       <= '0;
      light_r       <= '0;
      flip_r        <= 1'b0;
    end else begin
      shift_count_r <= shift_count_nxt;
      shift_low_r   <= shift_low_nxt;
      shift_high_r  <= shift_high_nxt;
      pend_r        <= pend_nxt;
      headlight_r   <= headlight_nxt;
      swap_r        <= swap_nxt;
      fg_sel_r      <= fg_sel_nxt;
      map_r         <= map_nxt;
      vscroll_r     <= vscroll_nxt;
      left_r        <= left_nxt;
      right_r       <= right_nxt;
      light_r       <= light_nxt;
      flip_r        <= flip_nxt;
    end
  end

  a_pend_from_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(fire && item.op == OP_WRITE && item.reg_addr == REG_SHIFT_DATA))
    else $error("lookup pending without a shift data write");

  a_flip_needs_cabinet: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && item.reg_addr == REG_FLIP && !cocktail) |=> !flip_r)
    else $error("flip set on an upright cabinet");

  a_low_from_table: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> shift_low_r == $past(ram_a))
    else $error("shift low not taken from table lookup");

endmodule

// ===== sv/shifter_and_video_control_regs_core.sv =====
`timescale 1ns / 1ps
// top level: input register, output register and cabinet configuration register
// path: an accepted beat waits in the input register, its result is formed as it leaves
//   and is registered in the output register
// throughput: one beat per cycle unless the output stalls; a shift data write reads
//   both bytes from the dual-read table port, landing the cycle after, then forwarded
// reset: rst_n synchronous, clears control and video state; the shift table is not
//   cleared; the user must load entries before they are read, not enforced by the block
module shifter_and_video_control_regs_core
  import svc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // item beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_reg_addr,
  input  logic [7:0]  in_data,
  input  logic [10:0] in_table_addr,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_headlight_on,
  output logic        out_swap_colors,
  output logic [1:0]  out_map_select,
  output logic        out_fg_color_select,
  output logic [7:0]  out_vertical_scroll,
  output logic [7:0]  out_left_scroll,
  output logic [7:0]  out_right_scroll,
  output logic [7:0]  out_light_scroll,
  output logic        out_flip_screen,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // cabinet switch, the only register, at byte address 0
  logic cocktail_r;
  logic cfg_wr;

  // input register stage
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    s1_fire;

  // output register stage
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;

  logic    out_free;
  logic    in_fire;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // reads away from the cabinet switch return zero
  assign prdata = (paddr == CFG_ADDR_COCKTAIL) ? {31'd0, cocktail_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cocktail_r <= 1'b0;
    end else if (cfg_wr) begin
      cocktail_r <= pwdata[0];
    end
  end

  // handshakes: the output register frees when taken, the input register when it moves on
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op         <= in_op;
      s1_item_r.reg_addr   <= in_reg_addr;
      s1_item_r.data       <= in_data;
      s1_item_r.table_addr <= in_table_addr;
    end
  end

  // state update and result forming happen as the beat leaves the input register
  svc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .cocktail (cocktail_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_res_r.read_data;
  assign out_headlight_on    = out_res_r.headlight_on;
  assign out_swap_colors     = out_res_r.swap_colors;
  assign out_map_select      = out_res_r.map_select;
  assign out_fg_color_select = out_res_r.fg_color_select;
  assign out_vertical_scroll = out_res_r.vertical_scroll;
  assign out_left_scroll     = out_res_r.left_scroll;
  assign out_right_scroll    = out_res_r.right_scroll;
  assign out_light_scroll    = out_res_r.light_scroll;
  assign out_flip_screen     = out_res_r.flip_screen;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted beat lost before the input register");

  a_stage_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed beat lost before the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_fire)
    else $error("output register overwritten while stalled");

endmodule

// ===== test/svc_tb_pkg.sv =====
`timescale 1ns / 1ps
// testbench-side codes shared by the checker and the stimulus top
package svc_tb_pkg;

  // configuration register index: cabinet switch at byte address 0
  localparam logic [1:0] CFG_COCKTAIL = 2'd0;

  // operation code the block leaves undefined
  localparam logic [1:0] OP_SPARE = 2'd3;

endpackage

// ===== test/svc_result_checker.sv =====
`timescale 1ns / 1ps
// checker: follows item and result beats, predicts the register block status and compares
module svc_result_checker
  import svc_pkg::*;
  import svc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_reg_addr,
  input  logic [7:0]  in_data,
  input  logic [10:0] in_table_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic        out_headlight_on,
  input  logic        out_swap_colors,
  input  logic [1:0]  out_map_select,
  input  logic        out_fg_color_select,
  input  logic [7:0]  out_vertical_scroll,
  input  logic [7:0]  out_left_scroll,
  input  logic [7:0]  out_right_scroll,
  input  logic [7:0]  out_light_scroll,
  input  logic        out_flip_screen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);

  logic       cocktail;
  logic [2:0] shift_cnt;
  logic [7:0] low_byte;
  logic [7:0] high_byte;
  logic [7:0] table_mem [SHIFT_TABLE_DEPTH];
  logic [1:0] map_bits;
  logic       headlight;
  logic       swap;
  logic       fg_sel;
  logic       flip;
  logic [7:0] vscroll;
  logic [7:0] lscroll;
  logic [7:0] rscroll;
  logic [7:0] hscroll;
  result_t    status_due [$];
  result_t    want;

  initial fail_count = 0;

  // low n bits mirrored, bits above cleared
  function automatic logic [7:0] mirror(input logic [7:0] v, input int n);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[i] = v[n-1-i];
    end
    return r;
  endfunction

  task automatic apply_item(input logic [1:0] op, input logic [3:0] ra, input logic [7:0] d,
                            input logic [10:0] ta);
    result_t     res;
    logic [10:0] a_lo;
    logic [10:0] a_hi;
    res = '0;
    case (op)
      OP_WRITE: begin
        case (ra)
          REG_FLIP:         flip = cocktail & d[0];
          REG_SHIFT_COUNT:  shift_cnt = d[2:0];
          REG_SHIFT_DATA: begin
            a_lo = {shift_cnt, d};
            a_hi = {~shift_cnt, mirror(d, 8)};
            low_byte  = table_mem[a_lo];
            high_byte = mirror(table_mem[a_hi], 7);
          end
          REG_VIDEO: begin
            headlight   = d[0];
            swap        = d[2];
            map_bits[1] = d[3];
          end
          REG_LIGHT_SCROLL: hscroll = d;
          REG_LEFT_SCROLL:  lscroll = d;
          REG_RIGHT_SCROLL: rscroll = d;
          REG_VERT_SCROLL: begin
            vscroll     = 8'd255 - (d & VSCROLL_MASK);
            map_bits[0] = d[0];
            fg_sel      = d[0];
          end
          default: ;
        endcase
      end
      OP_READ: begin
        if (ra == REG_SHIFT_LOW) res.read_data = low_byte;
        else if (ra == REG_SHIFT_HIGH) res.read_data = high_byte;
      end
      OP_LOAD: table_mem[ta] = d;
      default: ;
    endcase
    res.headlight_on    = headlight;
    res.swap_colors     = swap;
    res.map_select      = map_bits;
    res.fg_color_select = fg_sel;
    res.vertical_scroll = vscroll;
    res.left_scroll     = lscroll;
    res.right_scroll    = rscroll;
    res.light_scroll    = hscroll;
    res.flip_screen     = flip;
    status_due.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cocktail  = 1'b0;
      shift_cnt = '0;
      low_byte  = '0;
      high_byte = '0;
      map_bits  = '0;
      headlight = 1'b0;
      swap      = 1'b0;
      fg_sel    = 1'b0;
      flip      = 1'b0;
      vscroll   = '0;
      lscroll   = '0;
      rscroll   = '0;
      hscroll   = '0;
      status_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == CFG_COCKTAIL) cocktail = pwdata[0];
        end else if (paddr == CFG_COCKTAIL && prdata !== {31'b0, cocktail}) begin
          $error("cocktail_cabinet readback: expected 0x%08h, got 0x%08h",
                 {31'b0, cocktail}, prdata);
          fail_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("headlight_on", 8'(want.headlight_on), 8'(out_headlight_on));
          check_field("swap_colors", 8'(want.swap_colors), 8'(out_swap_colors));
          check_field("map_select", 8'(want.map_select), 8'(out_map_select));
          check_field("fg_color_select", 8'(want.fg_color_select), 8'(out_fg_color_select));
          check_field("vertical_scroll", want.vertical_scroll, out_vertical_scroll);
          check_field("left_scroll", want.left_scroll, out_left_scroll);
          check_field("right_scroll", want.right_scroll, out_right_scroll);
          check_field("light_scroll", want.light_scroll, out_light_scroll);
          check_field("flip_screen", 8'(want.flip_screen), 8'(out_flip_screen));
        end
      end
      if (in_valid && in_ready) apply_item(in_op, in_reg_addr, in_data, in_table_addr);
    end
    outstanding = status_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, item and configuration stimulus, and the verdict
module tb_top
  import svc_pkg::*;
  import svc_tb_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [3:0]  in_reg_addr;
  logic [7:0]  in_data;
  logic [10:0] in_table_addr;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic        out_headlight_on;
  logic        out_swap_colors;
  logic [1:0]  out_map_select;
  logic        out_fg_color_select;
  logic [7:0]  out_vertical_scroll;
  logic [7:0]  out_left_scroll;
  logic [7:0]  out_right_scroll;
  logic [7:0]  out_light_scroll;
  logic        out_flip_screen;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;

  // table entries the stimulus has loaded; a shift lookup only ever touches these
  bit          loaded [SHIFT_TABLE_DEPTH];
  // shift count as the block holds it, tracked from our own writes
  logic [2:0]  cur_count;
  // when set, neither side idles: back-to-back beats
  bit          no_stall;
  int          n_items;
  int          n_lookups;
  int          n_settings;

  shifter_and_video_control_regs_core i_dut (.*);

  svc_result_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // table bytes lean towards the corners so that bit 7 of the high byte gets dropped often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // result side: random stalls unless a no-stall stretch is running
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!no_stall && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        n = pick_gap();
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // one beat on the item channel; valid stays up across back-to-back beats
  task automatic drive_beat(input logic [1:0] op, input logic [3:0] ra, input logic [7:0] d,
                            input logic [10:0] ta);
    int gap;
    gap = (!no_stall && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_reg_addr   <= ra;
    in_data       <= d;
    in_table_addr <= ta;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_SPARE) n_items++;
  endtask

  task automatic load_entry(input logic [10:0] a, input logic [7:0] v);
    loaded[a] = 1'b1;
    drive_beat(OP_LOAD, 4'($urandom), v, a);
  endtask

  // sends an item, first loading whatever table bytes a shift lookup would read
  task automatic send(input logic [1:0] op, input logic [3:0] ra, input logic [7:0] d,
                      input logic [10:0] ta);
    logic [10:0] a_lo;
    logic [10:0] a_hi;
    if (op == OP_WRITE && ra == REG_SHIFT_DATA) begin
      a_lo = {cur_count, d};
      a_hi = {~cur_count, bit_rev8(d)};
      if (!loaded[a_lo]) load_entry(a_lo, pick_byte());
      if (!loaded[a_hi]) load_entry(a_hi, pick_byte());
      n_lookups++;
    end
    if (op == OP_WRITE && ra == REG_SHIFT_COUNT) cur_count = d[2:0];
    if (op == OP_LOAD) loaded[ta] = 1'b1;
    drive_beat(op, ra, d, ta);
  endtask

  // setup cycle then access cycle; pready is waited for although it is tied high
  task automatic cfg_access(input logic wr, input logic [1:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop valid, let every expected result come back, then allow the pipeline to drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cabinet(input logic v);
    cfg_access(1'b1, CFG_COCKTAIL, {31'b0, v});
    cfg_access(1'b0, CFG_COCKTAIL, '0);
    n_settings++;
  endtask

  // corners of every field, each operation and every special case
  task automatic directed_items();
    // shift results straight after reset
    send(OP_READ, REG_SHIFT_LOW, 8'h00, 11'h7ff);
    send(OP_READ, REG_SHIFT_HIGH, 8'hff, 11'h000);
    // video register and scrolls at both ends
    send(OP_WRITE, REG_VIDEO, 8'hff, 11'h000);
    send(OP_WRITE, REG_VERT_SCROLL, 8'h00, 11'h7ff);
    send(OP_WRITE, REG_VERT_SCROLL, 8'hff, 11'h000);
    send(OP_WRITE, REG_VIDEO, 8'h00, 11'h7ff);
    send(OP_WRITE, REG_LIGHT_SCROLL, 8'hff, 11'h000);
    send(OP_WRITE, REG_LEFT_SCROLL, 8'h00, 11'h7ff);
    send(OP_WRITE, REG_RIGHT_SCROLL, 8'hff, 11'h000);
    // flip on an upright cabinet stays clear
    send(OP_WRITE, REG_FLIP, 8'hff, 11'h7ff);
    // unused write addresses, the sound command among them
    send(OP_WRITE, 4'd6, 8'hff, 11'h000);
    send(OP_WRITE, 4'd0, 8'hff, 11'h7ff);
    send(OP_WRITE, 4'd10, 8'hff, 11'h000);
    // highest count, lowest data: table entries 0x700 and 0x000, bit 7 set on the high byte
    send(OP_LOAD, 4'hf, 8'h5a, 11'h700);
    send(OP_LOAD, 4'h0, 8'hff, 11'h000);
    send(OP_WRITE, REG_SHIFT_COUNT, 8'hff, 11'h000);
    send(OP_WRITE, REG_SHIFT_DATA, 8'h00, 11'h7ff);
    send(OP_READ, REG_SHIFT_LOW, 8'h00, 11'h000);
    send(OP_READ, REG_SHIFT_HIGH, 8'h00, 11'h000);
    // lowest count, highest data: top entry of the table
    send(OP_LOAD, 4'h0, 8'h80, 11'h7ff);
    send(OP_LOAD, 4'hf, 8'h01, 11'h0ff);
    send(OP_WRITE, REG_SHIFT_COUNT, 8'h00, 11'h7ff);
    send(OP_WRITE, REG_SHIFT_DATA, 8'hff, 11'h000);
    send(OP_READ, REG_SHIFT_HIGH, 8'hff, 11'h7ff);
    send(OP_READ, REG_SHIFT_LOW, 8'hff, 11'h7ff);
    // undefined operation and a read of an address with nothing behind it
    send(OP_SPARE, 4'hf, 8'hff, 11'h7ff);
    send(OP_READ, 4'd3, 8'h00, 11'h000);
  endtask

  // shift sequences with random content, mixed with loose traffic
  task automatic random_items(input int count);
    int         target;
    int         pick;
    logic [3:0] ra;
    target = n_items + count;
    while (n_items < target) begin
      if ($urandom_range(0, 39) == 0) no_stall = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        if ($urandom_range(0, 1) == 1)
          send(OP_WRITE, REG_SHIFT_COUNT, 8'($urandom), 11'($urandom));
        send(OP_WRITE, REG_SHIFT_DATA, 8'($urandom), 11'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          send(OP_READ, REG_SHIFT_LOW, 8'($urandom), 11'($urandom));
          send(OP_READ, REG_SHIFT_HIGH, 8'($urandom), 11'($urandom));
        end else begin
          send(OP_READ, REG_SHIFT_HIGH, 8'($urandom), 11'($urandom));
          if ($urandom_range(0, 2) != 0)
            send(OP_READ, REG_SHIFT_LOW, 8'($urandom), 11'($urandom));
        end
      end else if (pick < 11) begin
        // any write address, unused ones included
        send(OP_WRITE, 4'($urandom), pick_byte(), 11'($urandom));
      end else if (pick < 14) begin
        case ($urandom_range(0, 5))
          0:       ra = REG_FLIP;
          1:       ra = REG_VIDEO;
          2:       ra = REG_LIGHT_SCROLL;
          3:       ra = REG_LEFT_SCROLL;
          4:       ra = REG_RIGHT_SCROLL;
          default: ra = REG_VERT_SCROLL;
        endcase
        send(OP_WRITE, ra, pick_byte(), 11'($urandom));
      end else if (pick < 17) begin
        send(OP_READ, 4'($urandom), 8'($urandom), 11'($urandom));
      end else if (pick < 19) begin
        send(OP_LOAD, 4'($urandom), pick_byte(), 11'($urandom));
      end else begin
        send(OP_SPARE, 4'($urandom), 8'($urandom), 11'($urandom));
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = '0;
    in_reg_addr   = '0;
    in_data       = '0;
    in_table_addr = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_count     = '0;
    no_stall      = 1'b0;
    n_items       = 0;
    n_lookups     = 0;
    n_settings    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // upright cabinet first, written explicitly although it is the reset value
    set_cabinet(1'b0);
    directed_items();
    random_items(170);

    // cocktail, upright, cocktail: flip writes only stick on a cocktail cabinet
    for (int s = 0; s < 3; s++) begin
      wait_idle();
      set_cabinet(s != 1);
      send(OP_WRITE, REG_FLIP, 8'hff, 11'h000);
      send(OP_WRITE, REG_FLIP, 8'hfe, 11'h7ff);
      send(OP_WRITE, REG_FLIP, 8'h01, 11'h000);
      random_items(180);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d item beats with %0d shift lookups over %0d cabinet settings",
             n_items, n_lookups, n_settings);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
